@@ rtl/tlwc_pkg.sv @@
// Package for the ticket lock with cancellation.
// Holds the window size, operation codes and status codes; no dependencies.
`default_nettype none

package tlwc_pkg;

    // Outstanding window; must be a power of two (slot = ticket low bits)
    localparam int SLOTS  = 64;
    localparam int SLOT_W = $clog2(SLOTS);

    localparam logic [2:0] OP_TAKE    = 3'd0;
    localparam logic [2:0] OP_CLAIM   = 3'd1;
    localparam logic [2:0] OP_RELEASE = 3'd2;
    localparam logic [2:0] OP_CANCEL  = 3'd3;
    localparam logic [2:0] OP_READ    = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_WAIT   = 2'd2;
    localparam logic [1:0] ST_REJECT = 2'd3;

endpackage

`default_nettype wire

@@ rtl/ticket_lock_with_cancel.sv @@
// Ticket lock with cancellation, top level.
// A request is captured in IDLE and executed in EXEC; its result is loaded into
// the output register from DONE. Release, a good cancel and a claim that cancels
// walk the cancel table before DONE in SKIP_RD then SKIP_CHK, again per skipped ticket.
// One request at a time; a result held by backpressure stalls the next request in DONE.
// Reset (i_rst_n low, synchronous): counters, owner, output valid and all cancel
// valid bits clear; the cancel table itself is not cleared.
`default_nettype none

module ticket_lock_with_cancel (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_op,
    input  wire logic [31:0] i_ticket,
    input  wire logic [7:0]  i_requester_id,
    // result channel
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_status,
    output logic [31:0]      o_issued_ticket,
    output logic [31:0]      o_current_turn
);
    import tlwc_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_EXEC     = 3'd1;
    localparam logic [2:0] S_SKIP_RD  = 3'd2;
    localparam logic [2:0] S_SKIP_CHK = 3'd3;
    localparam logic [2:0] S_DONE     = 3'd4;

    logic [2:0]  r_state;

    // captured request
    logic [2:0]  r_op;
    logic [31:0] r_ticket;
    logic [7:0]  r_id;

    // lock state
    logic [31:0] r_next;
    logic [31:0] r_turn;
    logic        r_owned;
    logic [7:0]  r_owner_id;
    logic [31:0] r_owner_num;

    // cancel table: ticket numbers in a memory, valid bits in flops
    logic [31:0]      r_cmem [SLOTS];
    logic [SLOTS-1:0] r_cvalid;
    logic [31:0]      r_rd_data;

    // result of the request in progress
    logic [1:0]  r_status;
    logic [31:0] r_issued;

    // output register, loaded from DONE
    logic        r_o_valid;
    logic [1:0]  r_o_status;
    logic [31:0] r_o_issued;
    logic [31:0] r_o_turn;

    // request decode, evaluated in S_EXEC against the current lock state
    logic [31:0]       outstanding;
    logic              take_ok;
    logic              in_win;
    logic              owner_hit;
    logic              rel_ok;
    logic              do_cancel;
    logic [SLOT_W-1:0] tkt_slot;
    logic [SLOT_W-1:0] turn_slot;
    logic              skip_hit;

    assign outstanding = r_next - r_turn;
    assign take_ok     = outstanding < 32'(SLOTS);
    assign in_win      = (r_ticket - r_turn) < outstanding;
    assign owner_hit   = r_owned && (r_owner_num == r_ticket);
    assign rel_ok      = owner_hit && (r_owner_id == r_id);
    assign tkt_slot    = r_ticket[SLOT_W-1:0];
    assign turn_slot   = r_turn[SLOT_W-1:0];
    // a claim at the turn while the lock is held by another ticket cancels the ticket
    assign do_cancel   = (r_state == S_EXEC) && in_win && !owner_hit &&
                         ((r_op == OP_CANCEL) ||
                          ((r_op == OP_CLAIM) && (r_ticket == r_turn) && r_owned));
    assign skip_hit    = r_cvalid[turn_slot] && (r_rd_data == r_turn);

    // table memory: write on cancel, registered read during the skip walk
    always_ff @(posedge i_clk) begin
        if (do_cancel) begin
            r_cmem[tkt_slot] <= r_ticket;
        end
        if (r_state == S_SKIP_RD) begin
            r_rd_data <= r_cmem[turn_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_next      <= '0;
            r_turn      <= '0;
            r_owned     <= 1'b0;
            r_owner_id  <= '0;
            r_owner_num <= '0;
            r_cvalid    <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            // DONE handles the output register itself
            if (r_o_valid && i_ready && (r_state != S_DONE)) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op     <= i_op;
                        r_ticket <= i_ticket;
                        r_id     <= i_requester_id;
                        r_state  <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_issued <= ((r_op == OP_TAKE) && take_ok) ? r_next : '0;
                    case (r_op)
                        OP_TAKE: begin
                            r_state <= S_DONE;
                            if (!take_ok) begin
                                r_status <= ST_FULL;
                            end else begin
                                r_next   <= r_next + 32'd1;
                                r_status <= ST_OK;
                            end
                        end
                        OP_CLAIM: begin
                            if (!in_win) begin
                                r_status <= ST_REJECT;
                                r_state  <= S_DONE;
                            end else if (r_ticket != r_turn) begin
                                r_status <= ST_WAIT;
                                r_state  <= S_DONE;
                            end else if (r_owned) begin
                                r_status <= ST_REJECT;
                                if (do_cancel) begin
                                    r_cvalid[tkt_slot] <= 1'b1;
                                    r_state            <= S_SKIP_RD;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end else begin
                                r_owned     <= 1'b1;
                                r_owner_id  <= r_id;
                                r_owner_num <= r_ticket;
                                r_status    <= ST_OK;
                                r_state     <= S_DONE;
                            end
                        end
                        OP_RELEASE: begin
                            if (rel_ok) begin
                                r_owned     <= 1'b0;
                                r_owner_id  <= '0;
                                r_owner_num <= '0;
                                r_turn      <= r_turn + 32'd1;
                                r_status    <= ST_OK;
                                r_state     <= S_SKIP_RD;
                            end else begin
                                r_status <= ST_REJECT;
                                r_state  <= S_DONE;
                            end
                        end
                        OP_CANCEL: begin
                            if (do_cancel) begin
                                r_cvalid[tkt_slot] <= 1'b1;
                                r_status           <= ST_OK;
                                r_state            <= S_SKIP_RD;
                            end else begin
                                r_status <= ST_REJECT;
                                r_state  <= S_DONE;
                            end
                        end
                        OP_READ: begin
                            r_status <= ST_OK;
                            r_state  <= S_DONE;
                        end
                        default: begin
                            r_status <= ST_REJECT;
                            r_state  <= S_DONE;
                        end
                    endcase
                end
                S_SKIP_RD: begin
                    r_state <= S_SKIP_CHK;
                end
                S_SKIP_CHK: begin
                    // consume one canceled ticket at the turn, or stop
                    if (skip_hit) begin
                        r_cvalid[turn_slot] <= 1'b0;
                        r_turn              <= r_turn + 32'd1;
                        r_state             <= S_SKIP_RD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_o_valid || i_ready) begin
                        r_o_valid  <= 1'b1;
                        r_o_status <= r_status;
                        r_o_issued <= r_issued;
                        r_o_turn   <= r_turn;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result register stays up while the next request is taken in
    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_o_valid;
    assign o_status        = r_o_status;
    assign o_issued_ticket = r_o_issued;
    assign o_current_turn  = r_o_turn;

    // never more than SLOTS tickets outstanding
    a_window_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next - r_turn) <= 32'(SLOTS))
        else $error("outstanding window exceeds SLOTS");

    // the holder always has the ticket at the turn
    a_owner_at_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_owned |-> (r_owner_num == r_turn))
        else $error("owner ticket differs from turn");

    // a live cancel entry at the turn slot always holds the turn's ticket
    a_entry_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SKIP_CHK && r_cvalid[turn_slot]) |-> (r_rd_data == r_turn))
        else $error("stale cancel entry at turn slot");

    // only a granted take carries a ticket
    a_issue_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_status != ST_OK) |-> (r_o_issued == 32'd0))
        else $error("ticket issued with failing status");

    // skip walk advances the turn by one per hit
    a_skip_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SKIP_CHK && skip_hit) |=> (r_turn == $past(r_turn) + 32'd1))
        else $error("skip did not advance turn");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking bench for ticket_lock_with_cancel: a directed sequence, then
// ~900 random requests checked by an in-bench lock predictor and scoreboard.
// Depends on rtl/tlwc_pkg.sv and rtl/ticket_lock_with_cancel.sv.

module tb;
    import tlwc_pkg::*;

    localparam int RANDOM_ITEMS = 900;
    // Worst request: one that skips a full window of canceled tickets.
    localparam int DRAIN_CYCLES = 4 + 2 * SLOTS + 20;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] issued;
        logic [31:0] turn;
    } t_lock_result;

    // Lock predictor plus queue of expected results.
    class t_lock_scoreboard;
        logic [31:0]  next_num;
        logic [31:0]  turn_num;
        bit           owned;
        logic [7:0]   owner_id;
        logic [31:0]  owner_tkt;
        logic [31:0]  cancel_tkt [SLOTS];
        bit           cancel_vld [SLOTS];
        t_lock_result expected_q [$];
        int           errors;

        function new();
            next_num  = '0;
            turn_num  = '0;
            owned     = 1'b0;
            owner_id  = '0;
            owner_tkt = '0;
            errors    = 0;
            foreach (cancel_vld[i]) begin
                cancel_vld[i] = 1'b0;
                cancel_tkt[i] = '0;
            end
        endfunction

        // ticket is outstanding: (t - turn) < (next - turn), mod 2^32
        function bit in_window(logic [31:0] t);
            logic [31:0] offs;
            logic [31:0] span;
            offs = t - turn_num;
            span = next_num - turn_num;
            return offs < span;
        endfunction

        // advance turn over a run of canceled tickets, one table entry each
        function void skip_canceled();
            logic [SLOT_W-1:0] slot;
            for (int n = 0; n < SLOTS; n++) begin
                slot = turn_num[SLOT_W-1:0];
                if (!cancel_vld[slot] || cancel_tkt[slot] != turn_num)
                    break;
                cancel_vld[slot] = 1'b0;
                turn_num = turn_num + 32'd1;
            end
        endfunction

        function void cancel_ticket(logic [31:0] t);
            cancel_tkt[t[SLOT_W-1:0]] = t;
            cancel_vld[t[SLOT_W-1:0]] = 1'b1;
            skip_canceled();
        endfunction

        // called once per accepted request
        function void note_request(logic [2:0] op, logic [31:0] t, logic [7:0] id);
            t_lock_result res;
            logic [31:0]  span;
            res.status = ST_REJECT;
            res.issued = '0;
            span = next_num - turn_num;
            case (op)
                OP_TAKE: begin
                    if (span >= SLOTS) begin
                        res.status = ST_FULL;
                    end else begin
                        res.issued = next_num;
                        next_num   = next_num + 32'd1;
                        res.status = ST_OK;
                    end
                end
                OP_CLAIM: begin
                    if (!in_window(t)) begin
                        res.status = ST_REJECT;
                    end else if (t != turn_num) begin
                        res.status = ST_WAIT;
                    end else if (owned) begin
                        // at turn but held: a foreign ticket is dropped
                        if (t != owner_tkt)
                            cancel_ticket(t);
                        res.status = ST_REJECT;
                    end else begin
                        owned      = 1'b1;
                        owner_id   = id;
                        owner_tkt  = t;
                        res.status = ST_OK;
                    end
                end
                OP_RELEASE: begin
                    if (owned && owner_id == id && owner_tkt == t) begin
                        owned     = 1'b0;
                        owner_id  = '0;
                        owner_tkt = '0;
                        turn_num  = turn_num + 32'd1;
                        skip_canceled();
                        res.status = ST_OK;
                    end
                end
                OP_CANCEL: begin
                    if (in_window(t) && !(owned && owner_tkt == t)) begin
                        cancel_ticket(t);
                        res.status = ST_OK;
                    end
                end
                OP_READ: res.status = ST_OK;
                default: res.status = ST_REJECT;
            endcase
            res.turn = turn_num;
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [1:0] status, logic [31:0] issued,
                                   logic [31:0] turn);
            t_lock_result exp_res;
            if (expected_q.size() == 0) begin
                $error("result with no request pending: status %0d issued %0h turn %0h",
                       status, issued, turn);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (status !== exp_res.status) begin
                $error("status: expected %0d, actual %0d", exp_res.status, status);
                errors++;
            end
            if (issued !== exp_res.issued) begin
                $error("issued_ticket: expected %0h, actual %0h", exp_res.issued, issued);
                errors++;
            end
            if (turn !== exp_res.turn) begin
                $error("current_turn: expected %0h, actual %0h", exp_res.turn, turn);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic [2:0]  i_op           = OP_READ;
    logic [31:0] i_ticket       = '0;
    logic [7:0]  i_requester_id = '0;
    logic        i_ready        = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [31:0] o_issued_ticket;
    logic [31:0] o_current_turn;

    // calm: no idling on either side while set
    bit               calm   = 1'b0;
    int unsigned      cycles = 0;
    t_lock_scoreboard board  = new();

    ticket_lock_with_cancel DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_ticket       (i_ticket),
        .i_requester_id (i_requester_id),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_issued_ticket(o_issued_ticket),
        .o_current_turn (o_current_turn)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog: generous bound on the whole run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("ticket_lock_with_cancel regression: fail");
            $finish;
        end
    end

    // Result side backpressure: ~25% stall, none during calm stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_ready <= 1'b0;
        else
            i_ready <= calm || ($urandom_range(0, 99) >= 25);
    end

    // Result monitor; values sampled are those present at the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            board.check_result(o_status, o_issued_ticket, o_current_turn);
    end

    // Present one request, with random idle cycles ahead of it, and hold it
    // until accepted. The predictor runs at the accepting edge.
    task automatic send_request(input logic [2:0] op, input logic [31:0] t,
                                input logic [7:0] id);
        while (!calm && $urandom_range(0, 99) < 25) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_op           <= op;
        i_ticket       <= t;
        i_requester_id <= id;
        do @(posedge i_clk); while (!o_ready);
        board.note_request(op, t, id);
    endtask

    // Ticket choice leans on the predicted state so that requests mostly land
    // in the outstanding window, at the turn, or on the owner's ticket.
    function automatic logic [31:0] pick_ticket();
        logic [31:0] span;
        int          r;
        span = board.next_num - board.turn_num;
        r    = $urandom_range(0, 99);
        if (r < 15 || span == 0)
            return $urandom;
        if (r < 20)
            return board.next_num;      // one past the window
        if (r < 45)
            return board.turn_num;
        if (r < 55 && board.owned)
            return board.owner_tkt;
        return board.turn_num + $urandom_range(0, span - 1);
    endfunction

    initial begin
        int          r;
        bit          fill;
        logic [2:0]  op;
        logic [31:0] t;
        logic [7:0]  id;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty-window rejects, bad ops, owner checks, cancel and skip.
        send_request(OP_READ,    32'd0,          8'd0);
        send_request(OP_CLAIM,   32'd0,          8'd0);    // nothing outstanding
        send_request(OP_CANCEL,  32'hFFFF_FFFF,  8'd0);    // outside window
        send_request(OP_RELEASE, 32'd0,          8'd0);    // lock not held
        send_request(3'd5,       32'hFFFF_FFFF,  8'hFF);   // unknown ops
        send_request(3'd6,       32'hFFFF_FFFF,  8'hFF);
        send_request(3'd7,       32'hFFFF_FFFF,  8'hFF);
        send_request(OP_TAKE,    32'd0,          8'd0);
        send_request(OP_TAKE,    32'd0,          8'd0);
        send_request(OP_TAKE,    32'd0,          8'd0);
        send_request(OP_TAKE,    32'd0,          8'd0);
        send_request(OP_CLAIM,   32'd1,          8'hA5);   // not yet turn
        send_request(OP_CLAIM,   32'd0,          8'd0);    // id zero is legal
        send_request(OP_CLAIM,   32'd0,          8'hFF);   // owner's own ticket again
        send_request(OP_CANCEL,  32'd0,          8'd0);    // owned ticket
        send_request(OP_CANCEL,  32'd1,          8'd0);
        send_request(OP_CANCEL,  32'd2,          8'd0);
        send_request(OP_CANCEL,  32'd2,          8'd0);    // repeat cancel
        send_request(OP_RELEASE, 32'd0,          8'hFF);   // wrong id
        send_request(OP_RELEASE, 32'd1,          8'd0);    // wrong ticket
        send_request(OP_RELEASE, 32'd0,          8'd0);    // turn skips 1 and 2
        send_request(OP_CLAIM,   32'd3,          8'hFF);
        send_request(OP_RELEASE, 32'd3,          8'hFF);
        send_request(OP_TAKE,    32'd0,          8'd0);
        send_request(OP_CANCEL,  32'd4,          8'd0);    // cancel at turn, skip

        // Random: alternating normal and fill phases; fill phases push the
        // window to full and pile up cancels for long skip runs.
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            calm = (k >= 300 && k < 450);
            fill = ((k / 150) % 2) == 1;
            r    = $urandom_range(0, 99);
            if (r < (fill ? 55 : 25))
                op = OP_TAKE;
            else if (r < (fill ? 65 : 50))
                op = OP_CLAIM;
            else if (r < (fill ? 75 : 72))
                op = OP_RELEASE;
            else if (r < 90)
                op = OP_CANCEL;
            else if (r < 95)
                op = OP_READ;
            else
                op = 3'($urandom_range(5, 7));

            t  = pick_ticket();
            id = 8'($urandom);
            if (op == OP_RELEASE && board.owned) begin
                // mostly a matching release, else a near miss
                if ($urandom_range(0, 9) < 7)
                    t = board.owner_tkt;
                if ($urandom_range(0, 3) != 0)
                    id = board.owner_id;
            end
            if (op == OP_TAKE && $urandom_range(0, 1) == 1)
                t = $urandom;   // ignored field, toggled anyway
            send_request(op, t, id);
        end
        i_valid <= 1'b0;
        calm = 1'b0;

        // Drain: every result in, then room for a stray late one.
        while (board.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.errors == 0 && board.expected_q.size() == 0)
            $display("ticket_lock_with_cancel regression: pass");
        else
            $display("ticket_lock_with_cancel regression: fail");
        $finish;
    end

endmodule
